// ===== hdl/wcc_pkg.sv =====
// ----------------------------------------------------------------------------
// wcc_pkg
// types and fixed constants of the wavelet convolution cut core
// ----------------------------------------------------------------------------
package wcc_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int TAP_BITS    = 16;
   localparam int COEF_FRAC   = 15;
   localparam int INDEX_BITS  = 5;
   localparam int COUNT_BITS  = 6;
   localparam int DELAY_BITS  = 5;
   localparam int SEEN_BITS   = 6;
   localparam int CSR_IDX_W   = 4;
   localparam int CSR_DATA_W  = 8;

   localparam logic [SEEN_BITS-1:0] SEEN_MAX = '1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_TAP_COUNT    = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_OUTPUT_DELAY = CSR_IDX_W'(1);

   // request kinds
   localparam logic REQ_TAP    = 1'b0;
   localparam logic REQ_SAMPLE = 1'b1;

   typedef struct packed {
      logic                          req_type;
      logic [INDEX_BITS-1:0]         tap_index;
      logic signed [TAP_BITS-1:0]    tap_value;
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          last_sample;
   } req_item_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] out_sample;
      logic                          last;
      logic                          saturated;
   } rsp_item_type;

endpackage

// ===== hdl/wavelet_convolution_cut_core.sv =====
// ----------------------------------------------------------------------------
// wavelet_convolution_cut_core
// trace convolution with a loaded wavelet, cut to trace length at a delay
// ----------------------------------------------------------------------------
// usage:
//  - csr channel writes tap_count (index 0) and output_delay (index 1);
//    csr_ready is always high, write only while no request is in flight
//  - a tap request writes one coefficient into the tap memory, no response
//  - a sample request shifts one trace sample into the delay line; its
//    convolution output leaves on the rsp channel unless it falls inside
//    the leading delay window, where it is dropped
//  - a sample marked last also pushes delay zero samples to flush the
//    remaining outputs; the final response carries last, then the delay
//    line and the sample counter clear
//  - one shared multiply-accumulate walks the taps, one tap per cycle: a
//    sample with an output runs from its accept through push, the tap walk,
//    drain, round and next before the next accept, and rsp_valid rises
//    after the round step; each flush output repeats push through next, a
//    tap request stays in idle, a dropped sample goes through push and next
//  - req_ready is high only while the sequencer is idle
//  - a finished response sits in the rsp register; the core keeps working
//    and only stalls in the round step if the previous response is unread
//  - reset clears the delay line, counters and control registers
//    (tap_count = 1, output_delay = 0); tap memory is undefined until written
// ----------------------------------------------------------------------------
module wavelet_convolution_cut_core #(
   parameter int MAX_TAPS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  wcc_pkg::req_item_type          req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output wcc_pkg::rsp_item_type          rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [wcc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [wcc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import wcc_pkg::*;

   localparam int IDX_W = $clog2(MAX_TAPS);
   localparam int K_W   = $clog2(MAX_TAPS + 1);
   localparam int PROD_W = SAMPLE_BITS + TAP_BITS;
   localparam int ACC_W = PROD_W + IDX_W + 1;

   localparam logic signed [ACC_W-1:0] ROUND_ADD = ACC_W'(1) << (COEF_FRAC - 1);
   localparam logic signed [ACC_W-1:0] SAT_HI =
      {{(ACC_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_PUSH  = 5'b00010,
      ST_MAC   = 5'b00100,
      ST_ROUND = 5'b01000,
      ST_NEXT  = 5'b10000
   } state_type;

   // state and control
   state_type state_ff, state_in;
   logic [COUNT_BITS-1:0] tap_count_ff, tap_count_in;
   logic [DELAY_BITS-1:0] output_delay_ff, output_delay_in;
   logic [K_W-1:0]        k_ff, k_in;
   logic [IDX_W-1:0]      d_ff, d_in;
   logic [IDX_W-1:0]      flush_left_ff, flush_left_in;
   logic                  end_ff, end_in;
   logic                  cur_last_ff, cur_last_in;
   logic [SEEN_BITS-1:0]  seen_ff, seen_in;
   logic [K_W-1:0]        issue_ff, issue_in;
   logic                  p1_ff, p1_in;
   logic                  p2_ff, p2_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // datapath
   logic signed [SAMPLE_BITS-1:0] push_x_ff, push_x_in;
   logic signed [SAMPLE_BITS-1:0] dl_ff [MAX_TAPS];
   logic signed [SAMPLE_BITS-1:0] dl_in [MAX_TAPS];
   logic signed [TAP_BITS-1:0]    tap_mem [MAX_TAPS];
   logic signed [TAP_BITS-1:0]    tap_rd_ff;
   logic signed [SAMPLE_BITS-1:0] x_rd_ff;
   logic signed [PROD_W-1:0]      prod_ff;
   logic signed [ACC_W-1:0]       acc_ff, acc_in;
   rsp_item_type                  rsp_ff, rsp_in;

   logic             req_fire;
   logic             tap_we;
   logic [IDX_W-1:0] rd_addr;
   logic             do_push;
   logic             do_clear;
   logic [K_W-1:0]   k_eff;
   logic [IDX_W-1:0] d_eff;
   logic signed [ACC_W-1:0] rounded;
   logic signed [ACC_W-1:0] quot;
   logic             rsp_load;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // effective tap count and delay from the csr values
   always_comb begin
      if (tap_count_ff == '0) begin
         k_eff = K_W'(1);
      end else if (32'(tap_count_ff) > MAX_TAPS) begin
         k_eff = K_W'(MAX_TAPS);
      end else begin
         k_eff = K_W'(tap_count_ff);
      end
      if (32'(output_delay_ff) > 32'(k_eff) - 1) begin
         d_eff = IDX_W'(k_eff - K_W'(1));
      end else begin
         d_eff = IDX_W'(output_delay_ff);
      end
   end

   // csr decode
   always_comb begin
      tap_count_in    = tap_count_ff;
      output_delay_in = output_delay_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_TAP_COUNT:    tap_count_in    = csr_wdata[COUNT_BITS-1:0];
            REG_OUTPUT_DELAY: output_delay_in = csr_wdata[DELAY_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign tap_we = req_fire && (req_data.req_type == REQ_TAP) &&
                   (32'(req_data.tap_index) < MAX_TAPS);

   // round half up, then clip to the sample range
   assign rounded = acc_ff + ROUND_ADD;
   assign quot    = rounded >>> COEF_FRAC;

   assign rd_addr = IDX_W'(issue_ff);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      k_in          = k_ff;
      d_in          = d_ff;
      flush_left_in = flush_left_ff;
      end_in        = end_ff;
      cur_last_in   = cur_last_ff;
      seen_in       = seen_ff;
      issue_in      = issue_ff;
      p1_in         = 1'b0;
      p2_in         = p1_ff;
      push_x_in     = push_x_ff;
      acc_in        = acc_ff;
      do_push       = 1'b0;
      do_clear      = 1'b0;
      rsp_load      = 1'b0;
      rsp_in        = rsp_ff;

      if (p2_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_data.req_type == REQ_SAMPLE)) begin
               push_x_in     = req_data.sample;
               k_in          = k_eff;
               d_in          = d_eff;
               end_in        = req_data.last_sample;
               flush_left_in = req_data.last_sample ? d_eff : '0;
               state_in      = ST_PUSH;
            end
         end
         ST_PUSH: begin
            do_push     = 1'b1;
            cur_last_in = end_ff && (flush_left_ff == '0);
            if (seen_ff != SEEN_MAX) begin
               seen_in = seen_ff + SEEN_BITS'(1);
            end
            if (seen_ff >= SEEN_BITS'(d_ff)) begin
               acc_in   = '0;
               issue_in = '0;
               state_in = ST_MAC;
            end else begin
               state_in = ST_NEXT;
            end
         end
         ST_MAC: begin
            if (issue_ff < k_ff) begin
               p1_in    = 1'b1;
               issue_in = issue_ff + K_W'(1);
            end else if (!p1_ff && !p2_ff) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               rsp_in.last = cur_last_ff;
               if (quot > SAT_HI) begin
                  rsp_in.out_sample = SAT_HI[SAMPLE_BITS-1:0];
                  rsp_in.saturated  = 1'b1;
               end else if (quot < SAT_LO) begin
                  rsp_in.out_sample = SAT_LO[SAMPLE_BITS-1:0];
                  rsp_in.saturated  = 1'b1;
               end else begin
                  rsp_in.out_sample = quot[SAMPLE_BITS-1:0];
                  rsp_in.saturated  = 1'b0;
               end
               state_in = ST_NEXT;
            end
         end
         ST_NEXT: begin
            if (flush_left_ff != '0) begin
               // flush step: push a zero sample
               push_x_in     = '0;
               flush_left_in = flush_left_ff - IDX_W'(1);
               state_in      = ST_PUSH;
            end else begin
               if (end_ff) begin
                  do_clear = 1'b1;
                  seen_in  = '0;
                  end_in   = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // delay line: shift on push, clear at trace end
   always_comb begin
      for (int i = 0; i < MAX_TAPS; i++) begin
         dl_in[i] = dl_ff[i];
      end
      if (do_push) begin
         dl_in[0] = push_x_ff;
         for (int i = 1; i < MAX_TAPS; i++) begin
            dl_in[i] = dl_ff[i-1];
         end
      end else if (do_clear) begin
         for (int i = 0; i < MAX_TAPS; i++) begin
            dl_in[i] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         tap_count_ff    <= COUNT_BITS'(1);
         output_delay_ff <= '0;
         k_ff            <= K_W'(1);
         d_ff            <= '0;
         flush_left_ff   <= '0;
         end_ff          <= 1'b0;
         cur_last_ff     <= 1'b0;
         seen_ff         <= '0;
         issue_ff        <= '0;
         p1_ff           <= 1'b0;
         p2_ff           <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         for (int i = 0; i < MAX_TAPS; i++) begin
            dl_ff[i] <= '0;
         end
      end else begin
         state_ff        <= state_in;
         tap_count_ff    <= tap_count_in;
         output_delay_ff <= output_delay_in;
         k_ff            <= k_in;
         d_ff            <= d_in;
         flush_left_ff   <= flush_left_in;
         end_ff          <= end_in;
         cur_last_ff     <= cur_last_in;
         seen_ff         <= seen_in;
         issue_ff        <= issue_in;
         p1_ff           <= p1_in;
         p2_ff           <= p2_in;
         rsp_valid_ff    <= rsp_valid_in;
         dl_ff           <= dl_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      push_x_ff <= push_x_in;
      acc_ff    <= acc_in;
      rsp_ff    <= rsp_in;
      x_rd_ff   <= dl_ff[rd_addr];
      prod_ff   <= tap_rd_ff * x_rd_ff;
   end

   // tap memory, registered read
   always_ff @(posedge clock) begin
      if (tap_we) begin
         tap_mem[IDX_W'(req_data.tap_index)] <= req_data.tap_value;
      end
      tap_rd_ff <= tap_mem[rd_addr];
   end

endmodule

// ===== dv/wavelet_convolution_cut_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wavelet_convolution_cut_core_test
// self-checking bench for the trace convolution core: requests are queued by
// a stimulus process and offered by a clocked driver. Each accepted request
// runs through an in-bench convolution predictor that fills a queue of
// expected outputs. A clocked monitor pops that queue on every accepted
// response and compares it field by field.
// ----------------------------------------------------------------------------
module wavelet_convolution_cut_core_test;
   import wcc_pkg::*;

   localparam int MAX_TAPS        = 32;
   localparam int SETTLE_CYCLES   = 60;     // longest single output plus margin
   localparam int RSP_HOLD_CYCLES = 400;    // long receiver hold-off
   localparam int RANDOM_ITEMS    = 8;      // at least this many requests per random phase
   localparam longint SAMPLE_MAX  = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
   localparam longint SAMPLE_MIN  = -SAMPLE_MAX - 1;
   // first register index that maps to nothing
   localparam logic [CSR_IDX_W-1:0] REG_FIRST_UNMAPPED = REG_OUTPUT_DELAY + 1'b1;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_item_type          req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_item_type          rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // idle percentages for each side, changed between phases
   int unsigned sender_idle_pct   = 11;
   int unsigned receiver_idle_pct = 71;

   // long receiver hold-off, counted in its own process
   logic        rsp_hold_start = 1'b0;
   int unsigned rsp_hold_left  = 0;

   // requests waiting to be offered, outputs waiting to be seen
   req_item_type pending_requests [$];
   rsp_item_type expected_outputs [$];

   // predictor copy of the core state and registers
   logic signed [TAP_BITS-1:0]    wavelet_taps [MAX_TAPS];
   logic signed [SAMPLE_BITS-1:0] trace_window [MAX_TAPS] = '{default: '0};
   logic [SEEN_BITS-1:0]          trace_pushes = '0;
   logic [COUNT_BITS-1:0]         model_tap_count = COUNT_BITS'(1);
   logic [DELAY_BITS-1:0]         model_output_delay = '0;

   // run statistics
   int unsigned mismatch_count = 0;
   int unsigned tap_loads = 0;
   int unsigned samples_sent = 0;
   int unsigned traces_closed = 0;
   int unsigned outputs_seen = 0;
   int unsigned outputs_clipped = 0;

   wavelet_convolution_cut_core #(
      .MAX_TAPS (MAX_TAPS)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   // ---------------------------------------------------------------------------
   // convolution predictor
   // ---------------------------------------------------------------------------

   // tap count 0 acts as 1, anything above the store size acts as the size
   function automatic int unsigned taps_in_use();
      if (model_tap_count == '0) return 1;
      if (model_tap_count > MAX_TAPS) return MAX_TAPS;
      return model_tap_count;
   endfunction

   // delay never exceeds the last tap position
   function automatic int unsigned delay_in_use(int unsigned k);
      return (model_output_delay > k - 1) ? k - 1 : model_output_delay;
   endfunction

   // shift one sample in and predict its output unless it sits in the delay window
   function automatic void shift_and_convolve(logic signed [SAMPLE_BITS-1:0] x,
                                              bit is_last);
      int unsigned  k;
      int unsigned  d;
      int unsigned  pos;
      int           i;
      longint       acc;
      longint       q;
      rsp_item_type y;
      k   = taps_in_use();
      d   = delay_in_use(k);
      pos = trace_pushes;
      for (i = MAX_TAPS - 1; i > 0; i--) begin
         trace_window[i] = trace_window[i - 1];
      end
      trace_window[0] = x;
      if (trace_pushes != SEEN_MAX) trace_pushes++;
      if (pos < d) return;
      acc = 0;
      for (i = 0; i < k; i++) begin
         acc += longint'(wavelet_taps[i]) * longint'(trace_window[i]);
      end
      // round half up, then floor shift
      q = (acc + (longint'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
      y.saturated = 1'b0;
      if (q > SAMPLE_MAX) begin
         q = SAMPLE_MAX;
         y.saturated = 1'b1;
      end else if (q < SAMPLE_MIN) begin
         q = SAMPLE_MIN;
         y.saturated = 1'b1;
      end
      y.out_sample = q[SAMPLE_BITS-1:0];
      y.last       = is_last;
      expected_outputs.push_back(y);
   endfunction

   function automatic void convolve_request(req_item_type r);
      int unsigned flush;
      int unsigned i;
      if (r.req_type == REQ_TAP) begin
         // index field is exactly as wide as the store, so every load lands
         wavelet_taps[r.tap_index] = r.tap_value;
         tap_loads++;
         return;
      end
      samples_sent++;
      if (!r.last_sample) begin
         shift_and_convolve(r.sample, 1'b0);
         return;
      end
      // last sample: push delay zeros to flush the tail, then clear the trace
      flush = delay_in_use(taps_in_use());
      shift_and_convolve(r.sample, flush == 0);
      for (i = 0; i < flush; i++) begin
         shift_and_convolve('0, i + 1 == flush);
      end
      trace_window  = '{default: '0};
      trace_pushes  = '0;
      traces_closed++;
   endfunction

   // ---------------------------------------------------------------------------
   // request builders and value pickers
   // ---------------------------------------------------------------------------

   // sample fields carry noise on tap loads
   function automatic req_item_type tap_request(logic [INDEX_BITS-1:0] index,
                                                logic signed [TAP_BITS-1:0] value);
      req_item_type r;
      r.req_type    = REQ_TAP;
      r.tap_index   = index;
      r.tap_value   = value;
      r.sample      = SAMPLE_BITS'($urandom);
      r.last_sample = 1'($urandom);
      return r;
   endfunction

   // tap fields carry noise on samples
   function automatic req_item_type sample_request(logic signed [SAMPLE_BITS-1:0] x,
                                                   bit is_last);
      req_item_type r;
      r.req_type    = REQ_SAMPLE;
      r.tap_index   = INDEX_BITS'($urandom);
      r.tap_value   = TAP_BITS'($urandom);
      r.sample      = x;
      r.last_sample = is_last;
      return r;
   endfunction

   // mix of full-scale, small and uniform values
   function automatic logic signed [15:0] pick_value();
      case ($urandom_range(7))
         0:       return 16'sh7fff;
         1:       return 16'sh8000;
         2, 3:    return 16'($signed($urandom_range(128)) - 64);
         default: return 16'($urandom);
      endcase
   endfunction

   // ---------------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------------

   // wait until every request is taken and every output is back, then let
   // a tap load or dropped sample still in the core finish
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_requests.size() != 0 || req_valid || expected_outputs.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] index,
                                 logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (index == REG_TAP_COUNT) model_tap_count = value[COUNT_BITS-1:0];
      else if (index == REG_OUTPUT_DELAY) model_output_delay = value[DELAY_BITS-1:0];
   endtask

   // random upper bits check that the core masks the register width
   task automatic set_config(logic [COUNT_BITS-1:0] k, logic [DELAY_BITS-1:0] d);
      write_register(REG_TAP_COUNT, {2'($urandom), k});
      write_register(REG_OUTPUT_DELAY, {3'($urandom), d});
   endtask

   task automatic queue_trace(int unsigned len);
      int unsigned i;
      for (i = 0; i < len; i++) begin
         pending_requests.push_back(sample_request(pick_value(), i == len - 1));
      end
   endtask

   // mostly short traces, some medium, a few longer than the whole delay line
   task automatic queue_random_traces(int unsigned n_items);
      int unsigned queued;
      int unsigned len;
      int unsigned i;
      queued = 0;
      while (queued < n_items) begin
         case ($urandom_range(19))
            0:       len = $urandom_range(40, 33);
            1, 2, 3: len = $urandom_range(20, 9);
            default: len = $urandom_range(8, 1);
         endcase
         for (i = 0; i < len; i++) begin
            // occasional tap reload inside a trace
            if ($urandom_range(9) == 0) begin
               pending_requests.push_back(tap_request(INDEX_BITS'($urandom), pick_value()));
               queued++;
            end
            pending_requests.push_back(sample_request(pick_value(), i == len - 1));
            queued++;
         end
      end
   endtask

   // ---------------------------------------------------------------------------
   // request driver: offers queued requests, predicts on acceptance
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            convolve_request(req_data);
         end
         // a new request may go out only once the current one is taken
         if (!req_valid || req_ready) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               req_valid <= 1'b1;
               req_data  <= pending_requests.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // response monitor: compares against the oldest expected output
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            outputs_seen++;
            if (rsp_data.saturated) outputs_clipped++;
            if (expected_outputs.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected output, expected none, actual %0d/%0b/%0b",
                        $time, rsp_data.out_sample, rsp_data.last, rsp_data.saturated);
            end else begin
               want = expected_outputs.pop_front();
               if (rsp_data.out_sample !== want.out_sample || rsp_data.last !== want.last ||
                   rsp_data.saturated !== want.saturated) begin
                  mismatch_count++;
                  $display("%0t: output mismatch (sample/last/sat), expected %0d/%0b/%0b",
                           $time, want.out_sample, want.last, want.saturated,
                           ", actual %0d/%0b/%0b",
                           rsp_data.out_sample, rsp_data.last, rsp_data.saturated);
               end
            end
         end
         rsp_ready <= (rsp_hold_left == 0) && ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   // receiver hold-off counter
   always @(posedge clock) begin
      if (rsp_hold_start) rsp_hold_left <= RSP_HOLD_CYCLES;
      else if (rsp_hold_left != 0) rsp_hold_left <= rsp_hold_left - 1;
   end

   // ---------------------------------------------------------------------------
   // stimulus sequence
   // ---------------------------------------------------------------------------
   initial begin
      int unsigned i;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // single tap at reset settings: full-scale positive weight
      pending_requests.push_back(tap_request('0, 16'sh7fff));
      pending_requests.push_back(sample_request(16'sh7fff, 1'b0));
      pending_requests.push_back(sample_request(16'sh8000, 1'b0));
      pending_requests.push_back(sample_request(16'sh0000, 1'b0));
      pending_requests.push_back(sample_request(16'sh0001, 1'b0));
      pending_requests.push_back(sample_request(-16'sh0001, 1'b1));
      // full-scale negative weight, min times min clips high
      pending_requests.push_back(tap_request('0, 16'sh8000));
      pending_requests.push_back(sample_request(16'sh8000, 1'b0));
      pending_requests.push_back(sample_request(16'sh7fff, 1'b0));
      // half weight loaded mid trace gives exact rounding ties
      pending_requests.push_back(tap_request('0, 16'sh4000));
      pending_requests.push_back(sample_request(16'sh0001, 1'b0));
      pending_requests.push_back(sample_request(-16'sh0001, 1'b0));
      pending_requests.push_back(sample_request(16'sh0003, 1'b0));
      pending_requests.push_back(sample_request(-16'sh0003, 1'b1));
      wait_drained();

      // fill the whole tap store so no tap count reads an unwritten entry
      for (i = 0; i < MAX_TAPS; i++) begin
         pending_requests.push_back(tap_request(INDEX_BITS'(i), pick_value()));
      end
      wait_drained();

      // tap count above range and the largest delay, short trace
      set_config(COUNT_BITS'(63), DELAY_BITS'(31));
      pending_requests.push_back(sample_request(16'sh7fff, 1'b0));
      pending_requests.push_back(sample_request(16'sh8000, 1'b0));
      pending_requests.push_back(sample_request(16'sh0005, 1'b1));
      wait_drained();

      // tap count zero acts as one, delay clamps to zero
      set_config('0, DELAY_BITS'(7));
      queue_trace(2);
      wait_drained();

      // delay clamps to taps minus one, one-sample trace flushed to its end
      set_config(COUNT_BITS'(4), DELAY_BITS'(31));
      queue_trace(1);
      queue_trace(5);
      wait_drained();

      // writes to unmapped indexes change nothing
      write_register(REG_FIRST_UNMAPPED, 8'($urandom));
      write_register('1, 8'($urandom));
      queue_trace(4);
      wait_drained();

      // random phase with a slow receiver
      set_config(COUNT_BITS'($urandom_range(32, 1)), DELAY_BITS'($urandom_range(31)));
      queue_random_traces(RANDOM_ITEMS);
      wait_drained();

      // random phase with a slow sender
      sender_idle_pct   = 71;
      receiver_idle_pct = 11;
      set_config(COUNT_BITS'($urandom_range(32, 1)), DELAY_BITS'($urandom_range(31)));
      queue_random_traces(RANDOM_ITEMS);
      wait_drained();

      // no idling: hold the receiver off while a long trace backs up the core
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      set_config(COUNT_BITS'(32), '0);
      queue_trace(16);
      @(posedge clock);
      rsp_hold_start <= 1'b1;
      @(posedge clock);
      rsp_hold_start <= 1'b0;
      wait_drained();

      set_config(COUNT_BITS'($urandom_range(32, 1)), DELAY_BITS'($urandom_range(31)));
      queue_random_traces(RANDOM_ITEMS);
      wait_drained();

      $display("run covered %0d tap loads and %0d samples in %0d closed traces",
               tap_loads, samples_sent, traces_closed);
      $display("%0d outputs checked, %0d of them clipped, %0d mismatches",
               outputs_seen, outputs_clipped, mismatch_count);
      if (mismatch_count == 0 && expected_outputs.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // watchdog, many times the slowest correct run
   initial begin
      #400_000;
      $display("status: fail");
      $finish;
   end

endmodule
